### hdl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and types for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BITMAP_WORDS = 16384;
  localparam int BLOCK_BYTES  = 1024;
  localparam int WORD_BITS    = 32;
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);
  localparam int WIDX_W       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int CNT_W        = $clog2(BITMAP_WORDS + 1);
  localparam int BLK_W        = WIDX_W + BIT_W;
  localparam int NUM_BLOCKS   = BITMAP_WORDS * WORD_BITS;

  localparam int ADDR_W       = 30;
  localparam int BASE_W       = 25;
  localparam int STATUS_W     = 2;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 32;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(131072);

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_BAD_ADDR = 2'd2;
  localparam status_t ST_NOT_USED = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

### hdl/bba_find_free.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_find_free
// Finds the lowest clear bit of one bitmap word.
// ----------------------------------------------------------------------------
module bba_find_free (
  input  logic [bba_pkg::WORD_BITS-1:0] word,
  output logic                          found,
  output logic [bba_pkg::BIT_W-1:0]     bit_idx
);

  logic [bba_pkg::WORD_BITS-1:0] low_zero;

  // one-hot of the lowest zero bit
  assign low_zero = ~word & (word + bba_pkg::WORD_BITS'(1));
  assign found    = ~(&word);

  always_comb begin
    for (int j = 0; j < bba_pkg::BIT_W; j++) begin
      bit_idx[j] = 1'b0;
      for (int k = 0; k < bba_pkg::WORD_BITS; k++) begin
        if (((k >> j) & 1) == 1) begin
          bit_idx[j] = bit_idx[j] | low_zero[k];
        end
      end
    end
  end

endmodule

### hdl/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator of fixed-size blocks over a used-bit bitmap in RAM.
// ----------------------------------------------------------------------------
// Free: accept, read, modify/write, then out; a rejected address goes straight to out.
// Allocate: read from the first-free hint, stepping over full words at
//   one RAM word read per cycle; a hint already past the end reports full without a read.
// One item in flight at a time.
// Reset clears the high-water mark and hint; RAM words above the mark read as
//   zero, so no clearing pass is needed. region_base resets to 131072.
module bitmap_block_allocator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bba_pkg::BASE_W-1:0]       cfg_data,    // region_base
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bba_pkg::IN_DATA_W-1:0]    s_tdata,     // [29:0] free_address, pad
  input  logic                             s_tuser,     // [0] opcode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0]   m_tdata      // [29:0] granted_address, [31:30] status
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_FREE, S_DONE} state_t;

  state_t                           state;
  logic [bba_pkg::BASE_W-1:0]       base;
  logic [bba_pkg::CNT_W-1:0]        hwm;
  logic [bba_pkg::CNT_W-1:0]        hint;
  logic [bba_pkg::CNT_W-1:0]        scan;
  logic [bba_pkg::WIDX_W-1:0]       widx;
  logic [bba_pkg::BIT_W-1:0]        fbit;
  logic                             op;
  logic [bba_pkg::ADDR_W-1:0]       res_addr;
  bba_pkg::status_t                 res_status;

  logic [bba_pkg::WORD_BITS-1:0]    mem [bba_pkg::BITMAP_WORDS];
  logic [bba_pkg::WORD_BITS-1:0]    rd_data;
  logic [bba_pkg::WIDX_W-1:0]       rd_addr;
  logic                             wr_en;
  logic [bba_pkg::WORD_BITS-1:0]    wr_data;

  logic [bba_pkg::CNT_W-1:0]        scan_next;
  logic [bba_pkg::CNT_W-1:0]        word_num;
  logic [bba_pkg::WORD_BITS-1:0]    word;
  logic                             found;
  logic [bba_pkg::BIT_W-1:0]        bit_idx;
  logic [bba_pkg::WORD_BITS-1:0]    set_word;
  logic [bba_pkg::WORD_BITS-1:0]    fmask;
  logic [bba_pkg::BLK_W:0]          blk_inc;
  logic [bba_pkg::ADDR_W-1:0]       grant;

  logic [bba_pkg::ADDR_W:0]         first;
  logic [bba_pkg::ADDR_W-1:0]       in_addr;
  logic [bba_pkg::ADDR_W-1:0]       off;
  logic [bba_pkg::ADDR_W-1:0]       blk;
  logic                             bad;
  logic                             accept;
  logic                             out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign out_free  = ~m_tvalid | m_tready;

  // free address decode
  assign in_addr = s_tdata[bba_pkg::ADDR_W-1:0];
  assign first   = (bba_pkg::ADDR_W+1)'(base) + (bba_pkg::ADDR_W+1)'(bba_pkg::BLOCK_BYTES);
  assign off     = in_addr - first[bba_pkg::ADDR_W-1:0];
  assign blk     = off >> bba_pkg::BLOCK_SHIFT;
  assign bad     = ({1'b0, in_addr} < first)
                 | (|off[bba_pkg::BLOCK_SHIFT-1:0])
                 | (blk >= bba_pkg::ADDR_W'(bba_pkg::NUM_BLOCKS));

  // word under evaluation; above the high-water mark it was never written
  assign word_num = (state == S_SCAN) ? scan : bba_pkg::CNT_W'(widx);
  assign word     = (word_num < hwm) ? rd_data : '0;

  bba_find_free u_find (
    .word    (word),
    .found   (found),
    .bit_idx (bit_idx)
  );

  assign scan_next = scan + bba_pkg::CNT_W'(1);
  assign set_word  = word | (bba_pkg::WORD_BITS'(1) << bit_idx);
  assign fmask     = bba_pkg::WORD_BITS'(1) << fbit;
  assign blk_inc   = {1'b0, scan[bba_pkg::WIDX_W-1:0], bit_idx} + (bba_pkg::BLK_W+1)'(1);
  assign grant     = (bba_pkg::ADDR_W'(blk_inc) << bba_pkg::BLOCK_SHIFT)
                   + bba_pkg::ADDR_W'(base);

  always_comb begin
    rd_addr = widx;
    wr_en   = 1'b0;
    wr_data = set_word;
    case (state)
      S_SCAN: begin
        rd_addr = scan_next[bba_pkg::WIDX_W-1:0];
        wr_en   = found;
      end
      S_FREE: begin
        wr_en   = |(word & fmask);
        wr_data = word & ~fmask;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[(state == S_SCAN) ? scan[bba_pkg::WIDX_W-1:0] : widx] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      base     <= bba_pkg::BASE_RESET;
      hwm      <= '0;
      hint     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base <= cfg_data;
      end
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op <= s_tuser;
            if (s_tuser == bba_pkg::OP_ALLOC) begin
              scan <= hint;
              widx <= hint[bba_pkg::WIDX_W-1:0];
              if (hint == bba_pkg::CNT_W'(bba_pkg::BITMAP_WORDS)) begin
                res_addr   <= '0;
                res_status <= bba_pkg::ST_FULL;
                state      <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end else begin
              widx <= blk[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
              fbit <= blk[bba_pkg::BIT_W-1:0];
              if (bad) begin
                res_addr   <= '0;
                res_status <= bba_pkg::ST_BAD_ADDR;
                state      <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          state <= (op == bba_pkg::OP_ALLOC) ? S_SCAN : S_FREE;
        end
        S_SCAN: begin
          if (found) begin
            hint       <= (&set_word) ? scan_next : scan;
            if (scan >= hwm) begin
              hwm <= scan_next;
            end
            res_addr   <= grant;
            res_status <= bba_pkg::ST_OK;
            state      <= S_DONE;
          end else begin
            hint <= scan_next;
            scan <= scan_next;
            if (scan_next == bba_pkg::CNT_W'(bba_pkg::BITMAP_WORDS)) begin
              res_addr   <= '0;
              res_status <= bba_pkg::ST_FULL;
              state      <= S_DONE;
            end
          end
        end
        S_FREE: begin
          res_addr <= '0;
          if (|(word & fmask)) begin
            res_status <= bba_pkg::ST_OK;
            if (bba_pkg::CNT_W'(widx) < hint) begin
              hint <= bba_pkg::CNT_W'(widx);
            end
          end else begin
            res_status <= bba_pkg::ST_NOT_USED;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_status, res_addr};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/bba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bba_pkg::OUT_DATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_no_grant_on_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[31:30] != bba_pkg::ST_OK) |-> (m_tdata[29:0] == '0))
    else $error("nonzero address with error status");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while one is in flight");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
